FILE: rtl/bpt_pkg.sv
// Shared types and constants of the breakpoint table.
package bpt_pkg;

  localparam int unsigned ENTRIES_DEF = 32;
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned NUM_W       = 5;
  localparam int unsigned ACT_W       = 3;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [BYTE_W-1:0] TRAP_RESET = 8'hCC;

  typedef enum logic [ACT_W-1:0] {
    ACT_SET  = 3'd0,
    ACT_DEL  = 3'd1,
    ACT_DALL = 3'd2,
    ACT_FIND = 3'd3,
    ACT_MASK = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  // One slot of the data store.
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] saved_byte;
  } slot_t;

  // One result item.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NUM_W-1:0]    slot_number;
    logic [BYTE_W-1:0]   saved_byte;
    logic                write_valid;
    logic [ADDR_W-1:0]   write_address;
    logic [BYTE_W-1:0]   write_byte;
    logic                last;
  } res_t;

endpackage

FILE: rtl/breakpoint_table_with_free_list.sv
// Breakpoint table with a free list: streaming top level and trap byte register.
//
// Requests come in on the s_axis channel: tuser carries the action (set, delete
// by number, delete all, find by address, mask), tdata the address, the entry
// number and the original byte. Results leave on m_axis: tuser flags a patch
// write, tlast marks the final result of a request. cfg_* writes the trap byte
// and is always ready; write it only while no request is in flight.
//
// Requests are handled one at a time. Set reads the free top's link, then loads
// its result. Delete, find and delete all walk the active list through the link
// and slot memories at one slot per cycle; a delete in mid list then relinks
// its predecessor in S_DEL2. Mask emits one restore request per active slot
// per cycle while the receiver is ready, up to 32. The result register lets
// the next request be accepted while a result waits.
//
// Reset empties the active list and stacks all slots on the free list in
// index order; it takes effect at once, no clearing pass is needed. A stalled
// receiver holds the result register and pauses any mask walk in place.
module breakpoint_table_with_free_list #(
  parameter int unsigned ENTRIES = bpt_pkg::ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // address[31:0], entry_number, original_byte, zero pad
  input  logic [2:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // status, slot_number, saved_byte, write_address,
                                      // write_byte, zero pad
  output logic [0:0]  m_axis_tuser,   // write_valid
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned LW = $clog2(ENTRIES+1);

  logic [bpt_pkg::BYTE_W-1:0] trap_q;
  logic                       rd_en;
  logic [IW-1:0]              rd_addr;
  logic [LW-1:0]              lk_rd_data;
  logic                       lk_we;
  logic [IW-1:0]              lk_wr_addr;
  logic [LW-1:0]              lk_wr_data;
  bpt_pkg::slot_t             sm_rd_data;
  logic                       sm_we;
  logic [IW-1:0]              sm_wr_addr;
  bpt_pkg::slot_t             sm_wr_data;
  bpt_pkg::res_t              res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trap_q <= bpt_pkg::TRAP_RESET;
    end else if (cfg_valid_i) begin
      trap_q <= cfg_data_i;
    end
  end

  bpt_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_action_i  (s_axis_tuser),
    .in_address_i (s_axis_tdata[31:0]),
    .in_num_i     (s_axis_tdata[36:32]),
    .in_orig_i    (s_axis_tdata[44:37]),
    .trap_byte_i  (trap_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .lk_rd_data_i (lk_rd_data),
    .lk_we_o      (lk_we),
    .lk_wr_addr_o (lk_wr_addr),
    .lk_wr_data_o (lk_wr_data),
    .sm_rd_data_i (sm_rd_data),
    .sm_we_o      (sm_we),
    .sm_wr_addr_o (sm_wr_addr),
    .sm_wr_data_o (sm_wr_data)
  );

  bpt_link_mem #(
    .ENTRIES(ENTRIES)
  ) u_link_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (lk_rd_data),
    .we_i      (lk_we),
    .wr_addr_i (lk_wr_addr),
    .wr_data_i (lk_wr_data)
  );

  bpt_slot_mem #(
    .ENTRIES(ENTRIES)
  ) u_slot_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (sm_rd_data),
    .we_i      (sm_we),
    .wr_addr_i (sm_wr_addr),
    .wr_data_i (sm_wr_data)
  );

  assign m_axis_tdata = {1'b0, res.write_byte, res.write_address, res.saved_byte,
                         res.slot_number, res.status};
  assign m_axis_tuser = res.write_valid;
  assign m_axis_tlast = res.last;

endmodule

FILE: rtl/bpt_link_mem.sv
// Link memory: next pointers of the free stack and the active list.
module bpt_link_mem #(
  parameter int unsigned ENTRIES = bpt_pkg::ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [$clog2(ENTRIES)-1:0]   rd_addr_i,
  output logic [$clog2(ENTRIES+1)-1:0] rd_data_o,
  input  logic                         we_i,
  input  logic [$clog2(ENTRIES)-1:0]   wr_addr_i,
  input  logic [$clog2(ENTRIES+1)-1:0] wr_data_i
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned LW = $clog2(ENTRIES+1);

  logic [LW-1:0]      mem [ENTRIES];
  logic [ENTRIES-1:0] written_q;
  logic [LW-1:0]      rd_q;
  logic               rd_written_q;
  logic [IW-1:0]      rd_idx_q;

  // An entry never written reads as its reset link, index plus one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (we_i) begin
      written_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q         <= mem[rd_addr_i];
      rd_written_q <= written_q[rd_addr_i];
      rd_idx_q     <= rd_addr_i;
    end
  end

  assign rd_data_o = rd_written_q ? rd_q : (LW'(rd_idx_q) + LW'(1));

endmodule

FILE: rtl/bpt_slot_mem.sv
// Slot data memory: breakpoint address and saved byte per slot.
module bpt_slot_mem #(
  parameter int unsigned ENTRIES = bpt_pkg::ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr_i,
  output bpt_pkg::slot_t             rd_data_o,
  input  logic                       we_i,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr_i,
  input  bpt_pkg::slot_t             wr_data_i
);

  bpt_pkg::slot_t mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

FILE: rtl/bpt_ctrl.sv
// Request sequencer: list walks, free stack updates and the result register.
module bpt_ctrl #(
  parameter int unsigned ENTRIES = bpt_pkg::ENTRIES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [bpt_pkg::ACT_W-1:0]          in_action_i,
  input  logic [bpt_pkg::ADDR_W-1:0]         in_address_i,
  input  logic [bpt_pkg::NUM_W-1:0]          in_num_i,
  input  logic [bpt_pkg::BYTE_W-1:0]         in_orig_i,
  input  logic [bpt_pkg::BYTE_W-1:0]         trap_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output bpt_pkg::res_t                      out_o,
  output logic                               rd_en_o,
  output logic [$clog2(ENTRIES)-1:0]         rd_addr_o,
  input  logic [$clog2(ENTRIES+1)-1:0]       lk_rd_data_i,
  output logic                               lk_we_o,
  output logic [$clog2(ENTRIES)-1:0]         lk_wr_addr_o,
  output logic [$clog2(ENTRIES+1)-1:0]       lk_wr_data_o,
  input  bpt_pkg::slot_t                     sm_rd_data_i,
  output logic                               sm_we_o,
  output logic [$clog2(ENTRIES)-1:0]         sm_wr_addr_o,
  output bpt_pkg::slot_t                     sm_wr_data_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned LW = $clog2(ENTRIES+1);
  localparam int unsigned CW = (IW > bpt_pkg::NUM_W) ? IW : bpt_pkg::NUM_W;
  localparam logic [LW-1:0] NIL = LW'(ENTRIES);
  localparam logic [bpt_pkg::CNT_W-1:0] CNT_LAST = bpt_pkg::CNT_W'(bpt_pkg::MAX_RESULTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET,
    S_WALK,
    S_DEL2,
    S_RESP
  } state_e;

  state_e                        state_q, state_d;
  logic [LW-1:0]                 head_q, head_d;
  logic [LW-1:0]                 free_q, free_d;
  logic [IW-1:0]                 cur_q, cur_d;
  logic [IW-1:0]                 prev_q, prev_d;
  logic                          prev_ok_q, prev_ok_d;
  logic [LW-1:0]                 next_q, next_d;
  logic [bpt_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [bpt_pkg::ACT_W-1:0]     act_q, act_d;
  logic [bpt_pkg::ADDR_W-1:0]    addr_q, addr_d;
  logic [bpt_pkg::NUM_W-1:0]     num_q, num_d;
  logic [bpt_pkg::BYTE_W-1:0]    orig_q, orig_d;
  logic [bpt_pkg::STATUS_W-1:0]  resp_status_q, resp_status_d;
  logic [bpt_pkg::NUM_W-1:0]     resp_slot_q, resp_slot_d;
  logic [bpt_pkg::BYTE_W-1:0]    resp_saved_q, resp_saved_d;
  logic                          out_valid_q, out_valid_d;
  bpt_pkg::res_t                 out_q, out_d;
  logic                          can_load;
  logic                          out_load;
  logic                          at_end;
  logic                          mask_last;

  assign can_load  = !out_valid_q || out_ready_i;
  assign at_end    = (lk_rd_data_i == NIL);
  assign mask_last = at_end || (cnt_q == CNT_LAST);

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    free_d        = free_q;
    cur_d         = cur_q;
    prev_d        = prev_q;
    prev_ok_d     = prev_ok_q;
    next_d        = next_q;
    cnt_d         = cnt_q;
    act_d         = act_q;
    addr_d        = addr_q;
    num_d         = num_q;
    orig_d        = orig_q;
    resp_status_d = resp_status_q;
    resp_slot_d   = resp_slot_q;
    resp_saved_d  = resp_saved_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_load      = 1'b0;
    rd_en_o       = 1'b0;
    rd_addr_o     = cur_q;
    lk_we_o       = 1'b0;
    lk_wr_addr_o  = cur_q;
    lk_wr_data_o  = free_q;
    sm_we_o       = 1'b0;
    sm_wr_addr_o  = free_q[IW-1:0];
    sm_wr_data_o  = '{address: addr_q, saved_byte: orig_q};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d        = in_action_i;
          addr_d       = in_address_i;
          num_d        = in_num_i;
          orig_d       = in_orig_i;
          resp_slot_d  = '0;
          resp_saved_d = '0;
          cnt_d        = '0;
          prev_ok_d    = 1'b0;
          case (in_action_i)
            bpt_pkg::ACT_SET: begin
              if (free_q == NIL) begin
                resp_status_d = bpt_pkg::ST_FULL;
                state_d       = S_RESP;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = free_q[IW-1:0];
                state_d   = S_SET;
              end
            end
            bpt_pkg::ACT_DEL, bpt_pkg::ACT_DALL, bpt_pkg::ACT_FIND,
            bpt_pkg::ACT_MASK: begin
              if (head_q == NIL) begin
                // empty list: delete and find miss, the others succeed
                resp_status_d = (in_action_i == bpt_pkg::ACT_DEL ||
                                 in_action_i == bpt_pkg::ACT_FIND) ?
                                bpt_pkg::ST_MISS : bpt_pkg::ST_OK;
                state_d       = S_RESP;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = head_q[IW-1:0];
                cur_d     = head_q[IW-1:0];
                state_d   = S_WALK;
              end
            end
            default: begin
              resp_status_d = bpt_pkg::ST_MISS;
              state_d       = S_RESP;
            end
          endcase
        end
      end

      S_SET: begin
        // pop the free top, link it at the head and request the trap patch
        if (can_load) begin
          lk_we_o      = 1'b1;
          lk_wr_addr_o = free_q[IW-1:0];
          lk_wr_data_o = head_q;
          sm_we_o      = 1'b1;
          head_d       = free_q;
          free_d       = lk_rd_data_i;
          out_d        = '{status: bpt_pkg::ST_OK,
                           slot_number: bpt_pkg::NUM_W'(free_q),
                           saved_byte: '0,
                           write_valid: 1'b1,
                           write_address: addr_q,
                           write_byte: trap_byte_i,
                           last: 1'b1};
          out_load     = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end

      S_WALK: begin
        // link and slot data of cur_q arrived this cycle
        case (act_q)
          bpt_pkg::ACT_DEL: begin
            if (CW'(cur_q) == CW'(num_q)) begin
              lk_we_o       = 1'b1;
              lk_wr_data_o  = free_q;
              free_d        = LW'(cur_q);
              resp_status_d = bpt_pkg::ST_OK;
              resp_slot_d   = bpt_pkg::NUM_W'(cur_q);
              if (!prev_ok_q) begin
                head_d  = lk_rd_data_i;
                state_d = S_RESP;
              end else begin
                next_d  = lk_rd_data_i;
                state_d = S_DEL2;
              end
            end else if (at_end) begin
              resp_status_d = bpt_pkg::ST_MISS;
              state_d       = S_RESP;
            end else begin
              prev_d    = cur_q;
              prev_ok_d = 1'b1;
              cur_d     = lk_rd_data_i[IW-1:0];
              rd_en_o   = 1'b1;
              rd_addr_o = lk_rd_data_i[IW-1:0];
            end
          end
          bpt_pkg::ACT_FIND: begin
            if (sm_rd_data_i.address == addr_q) begin
              resp_status_d = bpt_pkg::ST_OK;
              resp_slot_d   = bpt_pkg::NUM_W'(cur_q);
              resp_saved_d  = sm_rd_data_i.saved_byte;
              state_d       = S_RESP;
            end else if (at_end) begin
              resp_status_d = bpt_pkg::ST_MISS;
              state_d       = S_RESP;
            end else begin
              cur_d     = lk_rd_data_i[IW-1:0];
              rd_en_o   = 1'b1;
              rd_addr_o = lk_rd_data_i[IW-1:0];
            end
          end
          bpt_pkg::ACT_DALL: begin
            // the list already chains head to tail; hook the tail onto the old free top
            if (at_end) begin
              lk_we_o       = 1'b1;
              lk_wr_data_o  = free_q;
              free_d        = head_q;
              head_d        = NIL;
              resp_status_d = bpt_pkg::ST_OK;
              state_d       = S_RESP;
            end else begin
              cur_d     = lk_rd_data_i[IW-1:0];
              rd_en_o   = 1'b1;
              rd_addr_o = lk_rd_data_i[IW-1:0];
            end
          end
          bpt_pkg::ACT_MASK: begin
            if (can_load) begin
              out_d       = '{status: bpt_pkg::ST_OK,
                              slot_number: bpt_pkg::NUM_W'(cur_q),
                              saved_byte: sm_rd_data_i.saved_byte,
                              write_valid: 1'b1,
                              write_address: sm_rd_data_i.address,
                              write_byte: sm_rd_data_i.saved_byte,
                              last: mask_last};
              out_load    = 1'b1;
              out_valid_d = 1'b1;
              if (mask_last) begin
                state_d = S_IDLE;
              end else begin
                cnt_d     = cnt_q + 1'b1;
                cur_d     = lk_rd_data_i[IW-1:0];
                rd_en_o   = 1'b1;
                rd_addr_o = lk_rd_data_i[IW-1:0];
              end
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_DEL2: begin
        lk_we_o      = 1'b1;
        lk_wr_addr_o = prev_q;
        lk_wr_data_o = next_q;
        state_d      = S_RESP;
      end

      S_RESP: begin
        if (can_load) begin
          out_d       = '{status: resp_status_q,
                          slot_number: resp_slot_q,
                          saved_byte: resp_saved_q,
                          write_valid: 1'b0,
                          write_address: '0,
                          write_byte: '0,
                          last: 1'b1};
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      head_q        <= NIL;
      free_q        <= '0;
      cur_q         <= '0;
      prev_q        <= '0;
      prev_ok_q     <= 1'b0;
      next_q        <= '0;
      cnt_q         <= '0;
      act_q         <= '0;
      addr_q        <= '0;
      num_q         <= '0;
      orig_q        <= '0;
      resp_status_q <= '0;
      resp_slot_q   <= '0;
      resp_saved_q  <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      state_q       <= state_d;
      head_q        <= head_d;
      free_q        <= free_d;
      cur_q         <= cur_d;
      prev_q        <= prev_d;
      prev_ok_q     <= prev_ok_d;
      next_q        <= next_d;
      cnt_q         <= cnt_d;
      act_q         <= act_d;
      addr_q        <= addr_d;
      num_q         <= num_d;
      orig_q        <= orig_d;
      resp_status_q <= resp_status_d;
      resp_slot_q   <= resp_slot_d;
      resp_saved_q  <= resp_saved_d;
      out_valid_q   <= out_valid_d;
      out_q         <= out_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The active list and the free stack never share their first slot.
  a_head_free_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q != NIL) |-> (head_q != free_q))
    else $error("active head equals free top");

  // A walk never visits the slot on top of the free stack.
  a_walk_not_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (LW'(cur_q) != free_q))
    else $error("walk reached the free top");

  // Every accepted request leaves idle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("request accepted without leaving idle");

  // The final result of a request ends the request.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.last) |=> (state_q == S_IDLE))
    else $error("final result without return to idle");

endmodule
